[hdl/uart_register_model_assert.svh]
// Assertion macros shared by the UART register model RTL.
// Included by the register file and the top level; no other dependencies.
`ifndef UART_REGISTER_MODEL_ASSERT_SVH
`define UART_REGISTER_MODEL_ASSERT_SVH

`ifndef SYNTHESIS
// Check an implication on every rising edge outside reset
`define URM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("uart register model: assertion failed");
// Check that a condition is followed by a result in the next cycle
`define URM_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("uart register model: next-cycle assertion failed");
`else
`define URM_ASSERT(lbl, clk, rst_n, prop)
`define URM_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif

`endif

[hdl/urm_pkg.sv]
// Types, register offsets and bit positions for the UART register model.
// No dependencies; imported by urm_regfile and uart_register_model.
`timescale 1ns / 1ps
`default_nettype none

package urm_pkg;

	// Request kind carried in tuser
	typedef enum logic [1:0] {
		MODE_READ  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_RX    = 2'd2,
		MODE_BREAK = 2'd3
	} mode_t;

	// Register offsets (DLAB clear names)
	localparam logic [2:0] OFS_RBR = 3'd0;
	localparam logic [2:0] OFS_IER = 3'd1;
	localparam logic [2:0] OFS_IIR = 3'd2;
	localparam logic [2:0] OFS_LCR = 3'd3;
	localparam logic [2:0] OFS_MCR = 3'd4;
	localparam logic [2:0] OFS_LSR = 3'd5;
	localparam logic [2:0] OFS_MSR = 3'd6;
	localparam logic [2:0] OFS_SCR = 3'd7;

	// Interrupt identity codes
	localparam logic [7:0] IIR_NONE = 8'h01;
	localparam logic [7:0] IIR_THRI = 8'h02;
	localparam logic [7:0] IIR_RDI  = 8'h04;

	// Bit positions
	localparam int unsigned LCR_DLAB_BIT = 7;
	localparam int unsigned IER_RDI_BIT  = 0;
	localparam int unsigned IER_THRI_BIT = 1;

	// One accepted request
	typedef struct packed {
		mode_t      mode;
		logic [2:0] reg_offset;
		logic [7:0] data;
	} cmd_t;

	// One result
	typedef struct packed {
		logic       host_ready;
		logic [7:0] tx_byte;
		logic       tx_valid;
		logic       irq;
		logic [7:0] read_data;
	} res_t;

	// Interrupt identity; THRE is always set since transmit completes at once
	function automatic logic [7:0] ident(input logic dr, input logic [7:0] ier);
		logic [7:0] code;
		if (dr && ier[IER_RDI_BIT]) begin
			code = IIR_RDI;
		end else if (ier[IER_THRI_BIT]) begin
			code = IIR_THRI;
		end else begin
			code = IIR_NONE;
		end
		return code;
	endfunction

	// Line status image: TEMT and THRE fixed high, BI and DR kept
	function automatic logic [7:0] lsr_image(input logic bi, input logic dr);
		return {1'b0, 1'b1, 1'b1, bi, 3'b000, dr};
	endfunction

endpackage

`default_nettype wire

[hdl/urm_regfile.sv]
// UART register state and the combinational next-state update for one request.
// Depends on urm_pkg and uart_register_model_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "uart_register_model_assert.svh"

module urm_regfile (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire urm_pkg::cmd_t cmd,
	output urm_pkg::res_t      res
);
	import urm_pkg::*;

	logic [7:0]  rbr_q;
	logic [7:0]  ier_q;
	logic [7:0]  lcr_q;
	logic [7:0]  mcr_q;
	logic [7:0]  msr_q;
	logic [7:0]  scr_q;
	logic [15:0] div_q;
	logic        dr_q;
	logic        bi_q;

	logic [7:0]  rbr_d;
	logic [7:0]  ier_d;
	logic [7:0]  lcr_d;
	logic [7:0]  mcr_d;
	logic [7:0]  msr_d;
	logic [7:0]  scr_d;
	logic [15:0] div_d;
	logic        dr_d;
	logic        bi_d;
	logic        dlab;

	assign dlab = lcr_q[LCR_DLAB_BIT];

	// Decode the request, form next state and the result
	always_comb begin
		rbr_d = rbr_q;
		ier_d = ier_q;
		lcr_d = lcr_q;
		mcr_d = mcr_q;
		msr_d = msr_q;
		scr_d = scr_q;
		div_d = div_q;
		dr_d  = dr_q;
		bi_d  = bi_q;
		res   = '0;
		case (cmd.mode)
			MODE_READ: begin
				case (cmd.reg_offset)
					OFS_RBR: begin
						if (dlab) begin
							res.read_data = div_q[7:0];
						end else begin
							res.read_data  = rbr_q;
							dr_d           = 1'b0;
							bi_d           = 1'b0;
							res.host_ready = 1'b1;
						end
					end
					OFS_IER: res.read_data = dlab ? div_q[15:8] : ier_q;
					OFS_IIR: res.read_data = ident(dr_q, ier_q);
					OFS_LCR: res.read_data = lcr_q;
					OFS_MCR: res.read_data = mcr_q;
					OFS_LSR: res.read_data = lsr_image(bi_q, dr_q);
					OFS_MSR: res.read_data = msr_q;
					OFS_SCR: res.read_data = scr_q;
					default: res.read_data = scr_q;
				endcase
			end
			MODE_WRITE: begin
				case (cmd.reg_offset)
					OFS_RBR: begin
						if (dlab) begin
							div_d[7:0] = cmd.data;
						end else begin
							res.tx_valid = 1'b1;
							res.tx_byte  = cmd.data;
						end
					end
					OFS_IER: begin
						if (dlab) begin
							div_d[15:8] = cmd.data;
						end else begin
							ier_d = cmd.data;
						end
					end
					OFS_LCR: lcr_d = cmd.data;
					OFS_MCR: mcr_d = cmd.data;
					OFS_MSR: msr_d = cmd.data;
					OFS_SCR: scr_d = cmd.data;
					default: begin
						// IIR and LSR are read only: drop the write
					end
				endcase
			end
			MODE_RX: begin
				rbr_d = cmd.data;
				dr_d  = 1'b1;
			end
			MODE_BREAK: begin
				rbr_d = '0;
				dr_d  = 1'b1;
				bi_d  = 1'b1;
			end
			default: begin
			end
		endcase
		res.irq = (ident(dr_d, ier_d) != IIR_NONE);
	end

	// Hold state, advance on each request that passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rbr_q <= '0;
			ier_q <= '0;
			lcr_q <= '0;
			mcr_q <= '0;
			msr_q <= '0;
			scr_q <= '0;
			div_q <= '0;
			dr_q  <= 1'b0;
			bi_q  <= 1'b0;
		end else if (en) begin
			rbr_q <= rbr_d;
			ier_q <= ier_d;
			lcr_q <= lcr_d;
			mcr_q <= mcr_d;
			msr_q <= msr_d;
			scr_q <= scr_d;
			div_q <= div_d;
			dr_q  <= dr_d;
			bi_q  <= bi_d;
		end
	end

	// A break always leaves data ready with it
	`URM_ASSERT(a_bi_has_dr, clk, arst_n, bi_q |-> dr_q)
	// A receive buffer read clears both receive flags
	`URM_ASSERT_NEXT(a_rbr_read_clears, clk, arst_n, en && res.host_ready, !dr_q && !bi_q)
	// After a receive buffer read only the transmit interrupt can remain
	`URM_ASSERT(a_read_irq, clk, arst_n, res.host_ready |-> (res.irq == ier_q[IER_THRI_BIT]))

endmodule

`default_nettype wire

[hdl/uart_register_model.sv]
// Top level of the UART register model: input register, register file, result register.
// Depends on urm_pkg, urm_regfile and uart_register_model_assert.svh.
//
//   group  dir  payload                                          handshake
//   s_*    in   tuser[1:0]=mode, tdata[2:0]=reg_offset,          tvalid/tready
//               tdata[10:3]=data
//   m_*    out  tdata: read_data, irq, tx_valid, tx_byte,         tvalid/tready
//               host_ready
//
// One request per cycle while m_tready is high; the result shows on m_tvalid once the
// request has passed the input register, then the result register.
// The register file updates when a request moves from the input register into the
// result register, so requests act on the registers strictly in order.
// A stall on m_tready holds the result; the input register still takes one more request.
// Reset clears the UART registers and valid flags (LSR reads 0x60, IIR 0x01).
`timescale 1ns / 1ps
`default_nettype none
`include "uart_register_model_assert.svh"

module uart_register_model (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // reg_offset[2:0], data[10:3], zero pad
	input  wire logic [7:0]  s_tuser,   // mode[1:0], zero pad
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata    // read_data[7:0], irq[8], tx_valid[9],
	                                    // tx_byte[17:10], host_ready[18], zero pad
);
	import urm_pkg::*;

	logic  s1_valid_q;
	cmd_t  cmd_s1;
	logic  out_valid_q;
	res_t  res_s2;
	res_t  res_next;
	logic  advance;

	// Move the held request on when the result register is free or draining
	assign advance  = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1.mode       <= mode_t'(s_tuser[1:0]);
			cmd_s1.reg_offset <= s_tdata[2:0];
			cmd_s1.data       <= s_tdata[10:3];
		end
	end

	urm_regfile u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.cmd    (cmd_s1),
		.res    (res_next)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b00000, res_s2};

	// Input stalls only when both registers are full
	`URM_ASSERT(a_stall_full, clk, arst_n, !s_tready |-> (s1_valid_q && out_valid_q))
	// A sent byte and a receive buffer read never share one result
	`URM_ASSERT(a_tx_vs_read, clk, arst_n, m_tvalid |-> !(res_s2.tx_valid && res_s2.host_ready))
	// A request that advances always shows up as a result next cycle
	`URM_ASSERT_NEXT(a_advance_out, clk, arst_n, advance, m_tvalid)

endmodule

`default_nettype wire

[tb/uart_register_model_tb.sv]
// Self-checking bench for uart_register_model: directed and random register bus and line traffic.
// Depends on urm_pkg and the RTL; it predicts each result from its own copy of the UART registers.
`timescale 1ns / 1ps
`default_nettype none

module uart_register_model_tb;

	import urm_pkg::*;

	// Line status and control bits as the host sees them
	localparam logic [7:0] LS_DATA_READY = 8'h01;
	localparam logic [7:0] LS_BREAK      = 8'h10;
	localparam logic [7:0] LS_THR_EMPTY  = 8'h20;
	localparam logic [7:0] LS_TX_EMPTY   = 8'h40;
	localparam logic [7:0] IE_RX_DATA    = 8'h01;
	localparam logic [7:0] IE_TX_EMPTY   = 8'h02;
	localparam logic [7:0] LC_DLAB       = 8'h80;

	localparam int CYCLE_LIMIT    = 200000;
	localparam int RANDOM_PER_PHASE = 113;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [7:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;

	uart_register_model uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Bus requests waiting to be sent and results the UART owes
	cmd_t pending_requests[$];
	res_t expected_results[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int cycles = 0;

	// Shadow copy of the UART registers
	logic [7:0]  rx_buf = 8'h00;
	logic [7:0]  ier = 8'h00;
	logic [7:0]  iir = IIR_NONE;
	logic [7:0]  lcr = 8'h00;
	logic [7:0]  mcr = 8'h00;
	logic [7:0]  lsr = LS_THR_EMPTY | LS_TX_EMPTY;
	logic [7:0]  msr = 8'h00;
	logic [7:0]  scr = 8'h00;
	logic [15:0] divisor = 16'h0000;

	always #2 clk = ~clk;

	// Recompute the pending interrupt, receive data first
	function automatic void refresh_iir();
		if ((lsr & LS_DATA_READY) != 0 && (ier & IE_RX_DATA) != 0) begin
			iir = IIR_RDI;
		end else if ((lsr & LS_THR_EMPTY) != 0 && (ier & IE_TX_EMPTY) != 0) begin
			iir = IIR_THRI;
		end else begin
			iir = IIR_NONE;
		end
	endfunction

	// Apply one request to the shadow registers and return what the UART reports
	function automatic res_t uart_regs_apply(input cmd_t req);
		res_t r;
		logic dlab;
		r = '0;
		dlab = (lcr & LC_DLAB) != 0;
		case (req.mode)
			MODE_READ: begin
				case (req.reg_offset)
					OFS_RBR: begin
						if (dlab) begin
							r.read_data = divisor[7:0];
						end else begin
							r.read_data = rx_buf;
							lsr = lsr & ~(LS_DATA_READY | LS_BREAK);
							refresh_iir();
							r.host_ready = 1'b1;
						end
					end
					OFS_IER: r.read_data = dlab ? divisor[15:8] : ier;
					OFS_IIR: r.read_data = iir;
					OFS_LCR: r.read_data = lcr;
					OFS_MCR: r.read_data = mcr;
					OFS_LSR: r.read_data = lsr;
					OFS_MSR: r.read_data = msr;
					default: r.read_data = scr;
				endcase
			end
			MODE_WRITE: begin
				case (req.reg_offset)
					OFS_RBR: begin
						if (dlab) begin
							divisor[7:0] = req.data;
						end else begin
							r.tx_valid = 1'b1;
							r.tx_byte = req.data;
							lsr = lsr | LS_THR_EMPTY | LS_TX_EMPTY;
							refresh_iir();
						end
					end
					OFS_IER: begin
						if (dlab) begin
							divisor[15:8] = req.data;
						end else begin
							ier = req.data;
							refresh_iir();
						end
					end
					OFS_LCR: lcr = req.data;
					OFS_MCR: mcr = req.data;
					OFS_MSR: msr = req.data;
					OFS_SCR: scr = req.data;
					default: ;
				endcase
			end
			MODE_RX: begin
				rx_buf = req.data;
				lsr = lsr | LS_DATA_READY;
				refresh_iir();
			end
			default: begin
				rx_buf = 8'h00;
				lsr = lsr | LS_BREAK | LS_DATA_READY;
				refresh_iir();
			end
		endcase
		r.irq = (iir != IIR_NONE);
		return r;
	endfunction

	// Feed requests from the queue, predicting each one as it is accepted
	always @(posedge clk or negedge arst_n) begin : drive_requests
		cmd_t next_req;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(uart_regs_apply(
					'{mode_t'(s_tuser[1:0]), s_tdata[2:0], s_tdata[10:3]}));
			end
			if (!s_tvalid || s_tready) begin
				if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_req = pending_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {5'b0, next_req.data, next_req.reg_offset};
					s_tuser <= {6'b0, next_req.mode};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Stall the result side at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Compare each result with the oldest prediction
	always @(posedge clk) begin : check_results
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = res_t'(m_tdata[18:0]);
			if (expected_results.size() == 0) begin
				$error("unexpected result m_tdata=%h", m_tdata);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (got.read_data !== want.read_data) begin
					$error("read_data: expected %h, got %h", want.read_data, got.read_data);
					errors++;
				end
				if (got.irq !== want.irq) begin
					$error("irq: expected %b, got %b", want.irq, got.irq);
					errors++;
				end
				if (got.tx_valid !== want.tx_valid) begin
					$error("tx_valid: expected %b, got %b", want.tx_valid, got.tx_valid);
					errors++;
				end
				if (got.tx_byte !== want.tx_byte) begin
					$error("tx_byte: expected %h, got %h", want.tx_byte, got.tx_byte);
					errors++;
				end
				if (got.host_ready !== want.host_ready) begin
					$error("host_ready: expected %b, got %b", want.host_ready, got.host_ready);
					errors++;
				end
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic add_req(input mode_t m, input logic [2:0] ofs, input logic [7:0] d);
		pending_requests.push_back('{m, ofs, d});
	endtask

	// Random request: mostly bus traffic, some line events, edge data now and then
	task automatic add_random_req();
		int pick;
		mode_t m;
		logic [2:0] ofs;
		logic [7:0] d;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			m = MODE_READ;
		end else if (pick < 80) begin
			m = MODE_WRITE;
		end else if (pick < 92) begin
			m = MODE_RX;
		end else begin
			m = MODE_BREAK;
		end
		ofs = 3'($urandom_range(0, 7));
		case ($urandom_range(0, 7))
			0: d = 8'h00;
			1: d = 8'hff;
			default: d = 8'($urandom_range(0, 255));
		endcase
		// keep DLAB clear most of the time so the receive buffer stays reachable
		if (m == MODE_WRITE && ofs == OFS_LCR) begin
			d[7] = ($urandom_range(0, 2) == 0);
		end
		add_req(m, ofs, d);
	endtask

	// Hold off until every queued request went out and every result came back
	task automatic drain();
		while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin : stimulus
		int phase;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset values, interrupts, receive path, break, divisor latch
		add_req(MODE_READ,  OFS_LSR, 8'h00);
		add_req(MODE_READ,  OFS_IIR, 8'h00);
		add_req(MODE_WRITE, OFS_IER, 8'h03);
		add_req(MODE_READ,  OFS_IIR, 8'h00);
		add_req(MODE_RX,    OFS_SCR, 8'hff);
		add_req(MODE_READ,  OFS_IIR, 8'h00);
		add_req(MODE_RX,    OFS_RBR, 8'h00);
		add_req(MODE_READ,  OFS_RBR, 8'h00);
		add_req(MODE_BREAK, OFS_LSR, 8'hff);
		add_req(MODE_READ,  OFS_LSR, 8'h00);
		add_req(MODE_READ,  OFS_RBR, 8'h00);
		add_req(MODE_WRITE, OFS_RBR, 8'hff);
		add_req(MODE_WRITE, OFS_RBR, 8'h00);
		add_req(MODE_WRITE, OFS_IIR, 8'hff);
		add_req(MODE_WRITE, OFS_LSR, 8'hff);
		add_req(MODE_WRITE, OFS_MSR, 8'ha5);
		add_req(MODE_READ,  OFS_MSR, 8'h00);
		add_req(MODE_WRITE, OFS_MCR, 8'hff);
		add_req(MODE_WRITE, OFS_SCR, 8'hff);
		add_req(MODE_WRITE, OFS_LCR, 8'hff);
		add_req(MODE_WRITE, OFS_RBR, 8'hff);
		add_req(MODE_WRITE, OFS_IER, 8'h00);
		add_req(MODE_READ,  OFS_RBR, 8'h00);
		add_req(MODE_READ,  OFS_IER, 8'h00);
		add_req(MODE_WRITE, OFS_LCR, 8'h00);
		drain();

		// Random traffic under each idling pattern
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
				default: begin send_idle_pct = 23; recv_stall_pct = 23; end
			endcase
			repeat (RANDOM_PER_PHASE) add_random_req();
			drain();
		end

		// Let any stray result show up
		repeat (10) @(negedge clk);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire
